>>> sv/ledbpe_pkg.sv
// Shared types and constants of the LED panel bit-plane encoder.
// Depends on nothing; every other file of the block but the pattern store imports it.
package ledbpe_pkg;

   localparam int LEVEL_W   = 8;
   localparam int DEPTH_W   = 7;
   localparam int PLANE_W   = 6;
   localparam int PORT_W    = 2;
   localparam int CHAN_W    = 2;
   localparam int PROD_W    = 15;
   localparam int REM_W     = 6;
   localparam int NUM_SLOTS = 6;
   localparam int SLOT_W    = 3;

   localparam logic KIND_TABLE = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef enum logic [CHAN_W-1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } ledbpe_chan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SPREAD,
      ST_STORE,
      ST_FETCH,
      ST_DRAIN,
      ST_EMIT
   } ledbpe_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
   } ledbpe_spread_ctl_type;

   typedef struct packed {
      logic              en;
      logic              zero;
      logic [SLOT_W-1:0] slot;
   } ledbpe_cap_type;

   // Slots hold upper red, green, blue and then lower red, green, blue.
   function automatic ledbpe_chan_type slot_chan(input logic [SLOT_W-1:0] slot);
      ledbpe_chan_type chan;
      unique case (slot)
         3'd0, 3'd3: chan = CH_RED;
         3'd1, 3'd4: chan = CH_GREEN;
         3'd2, 3'd5: chan = CH_BLUE;
         default:    chan = CH_RED;
      endcase
      return chan;
   endfunction

endpackage

>>> sv/ledbpe_pattern_ram.sv
// Pattern store of the encoder: one write port and one registered read port.
// Depends on nothing beyond its parameters.
module ledbpe_pattern_ram #(
   parameter int ENTRIES = 768,
   parameter int WIDTH   = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [ENTRIES];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ledbpe_spread_unit.sv
// Builds an evenly spread pattern of ones, one plane position per cycle,
// with a single add and compare. Depends on ledbpe_pkg.
module ledbpe_spread_unit
   import ledbpe_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic                  clock,
   input  ledbpe_spread_ctl_type ctl,
   input  logic [LEVEL_W-1:0]    level,
   input  logic [DEPTH_W-1:0]    depth,
   output logic [WIDTH-1:0]      pattern,
   output logic                  last_step
);

   localparam int PIDX_W = $clog2(WIDTH);

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               nz_ff, nz_in;
   logic [DEPTH_W-1:0] count_ff, count_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [PLANE_W-1:0] pos_ff, pos_in;
   logic [WIDTH-1:0]   pattern_ff, pattern_in;
   logic [PROD_W:0]    div_sum;
   logic [DEPTH_W-1:0] quot;
   logic [DEPTH_W-1:0] sum;
   logic               hit;

   // Division by 255 through (x + x/256 + 1) / 256, exact over the product range.
   assign div_sum = {1'b0, prod_ff} + (PROD_W+1)'(prod_ff[PROD_W-1:8]) + (PROD_W+1)'(1);
   assign quot    = div_sum[PROD_W-1:8];
   assign sum     = DEPTH_W'(rem_ff) + count_ff;
   assign hit     = (sum >= depth);

   always_comb begin
      prod_in    = prod_ff;
      nz_in      = nz_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      pattern_in = pattern_ff;
      if (ctl.load) begin
         prod_in = PROD_W'(level) * PROD_W'(depth);
         nz_in   = |level;
      end
      if (ctl.setup) begin
         if (!nz_ff) begin
            count_in = '0;
         end else if (quot == '0) begin
            count_in = DEPTH_W'(1);
         end else begin
            count_in = quot;
         end
         rem_in     = REM_W'(depth - DEPTH_W'(1));
         pos_in     = '0;
         pattern_in = '0;
      end
      if (ctl.step) begin
         if (hit) begin
            rem_in                       = REM_W'(sum - depth);
            pattern_in[pos_ff[PIDX_W-1:0]] = 1'b1;
         end else begin
            rem_in = REM_W'(sum);
         end
         pos_in = pos_ff + PLANE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      nz_ff      <= nz_in;
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      pos_ff     <= pos_in;
      pattern_ff <= pattern_in;
   end

   assign pattern   = pattern_ff;
   assign last_step = ((DEPTH_W'(pos_ff) + DEPTH_W'(1)) == depth);

endmodule

>>> sv/ledbpe_plane_shifter.sv
// Holds the six looked-up patterns of a pixel pair and shifts out one plane
// at a time. Depends on ledbpe_pkg.
module ledbpe_plane_shifter
   import ledbpe_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  ledbpe_cap_type       cap,
   input  logic [WIDTH-1:0]     rd_data,
   input  logic                 shift_en,
   output logic [NUM_SLOTS-1:0] plane_bits
);

   logic [WIDTH-1:0] pat_ff [NUM_SLOTS];
   logic [WIDTH-1:0] pat_in [NUM_SLOTS];

   always_comb begin
      pat_in = pat_ff;
      if (cap.en) begin
         pat_in[cap.slot] = cap.zero ? '0 : rd_data;
      end
      if (shift_en) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            pat_in[k] = pat_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         plane_bits[k] = pat_ff[k][0];
      end
   end

endmodule

>>> sv/led_panel_bit_plane_encoder.sv
// Top level of the LED panel bit-plane encoder: sequencer, depth register,
// pattern store, spread unit and plane shifter. Depends on ledbpe_pkg.
//
//   channel | direction | handshake            | carries
//   req_    | in        | req_valid/req_stall  | table write or pixel pair
//   rsp_    | out       | rsp_valid/rsp_stall  | one plane of a pixel pair
//   csr_    | in        | csr_wr_en            | plane depth
//
// A table write keeps the block busy through the setup, spread and store states
// after its transaction: the spread unit settles one plane position per cycle.
// A pixel pair looks up its six patterns one after another through the single
// read port of the pattern store and captures the last pattern in the drain
// state, then gives one result transaction per plane, one per cycle unless
// stalled. Reset is synchronous and leaves the pattern store unwritten.
module led_panel_bit_plane_encoder
   import ledbpe_pkg::*;
#(
   parameter int LEVELS_PER_CHANNEL = 256,
   parameter int MAX_PLANES         = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [DEPTH_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [CHAN_W-1:0]  req_table_channel,
   input  logic [LEVEL_W-1:0] req_table_index,
   input  logic [LEVEL_W-1:0] req_table_level,
   input  logic [PORT_W-1:0]  req_port,
   input  logic [LEVEL_W-1:0] req_upper_red,
   input  logic [LEVEL_W-1:0] req_upper_green,
   input  logic [LEVEL_W-1:0] req_upper_blue,
   input  logic [LEVEL_W-1:0] req_lower_red,
   input  logic [LEVEL_W-1:0] req_lower_green,
   input  logic [LEVEL_W-1:0] req_lower_blue,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PORT_W-1:0]  rsp_out_port,
   output logic [PLANE_W-1:0] rsp_plane,
   output logic               rsp_red_one,
   output logic               rsp_red_two,
   output logic               rsp_green_one,
   output logic               rsp_green_two,
   output logic               rsp_blue_one,
   output logic               rsp_blue_two,
   output logic               rsp_last
);

   localparam int ENTRIES = 3 * LEVELS_PER_CHANNEL;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'(MAX_PLANES);
   localparam logic [DEPTH_W-1:0] DEPTH_RESET =
      DEPTH_W'((MAX_PLANES < 32) ? MAX_PLANES : 32);

   function automatic logic [ADDR_W-1:0] chan_base(input ledbpe_chan_type chan);
      logic [ADDR_W-1:0] base;
      unique case (chan)
         CH_RED:   base = '0;
         CH_GREEN: base = ADDR_W'(LEVELS_PER_CHANNEL);
         CH_BLUE:  base = ADDR_W'(2 * LEVELS_PER_CHANNEL);
         default:  base = '0;
      endcase
      return base;
   endfunction

   ledbpe_state_type      state_ff, state_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [PORT_W-1:0]     port_ff;
   logic [LEVEL_W-1:0]    comp_ff [NUM_SLOTS];
   logic [ADDR_W-1:0]     wr_addr_ff;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [PLANE_W-1:0]    plane_ff, plane_in;
   logic                  rd_valid_ff;
   logic [SLOT_W-1:0]     rd_slot_ff;
   logic                  rd_zero_ff;

   logic                  accept;
   logic                  write_ok;
   logic                  last_plane;
   logic                  spread_last;
   logic [MAX_PLANES-1:0] spread_pattern;
   logic [MAX_PLANES-1:0] rd_data;
   logic [ADDR_W-1:0]     table_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [LEVEL_W-1:0]    rd_comp;
   logic                  rd_zero;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic                  shift_en;
   logic [NUM_SLOTS-1:0]  plane_bits;
   ledbpe_spread_ctl_type spread_ctl;
   ledbpe_cap_type        cap;

   assign accept   = req_valid && !req_stall;
   assign write_ok = (req_table_channel != CHAN_W'(3)) &&
                     ({1'b0, req_table_index} < (LEVEL_W+1)'(LEVELS_PER_CHANNEL));
   assign table_addr = chan_base(ledbpe_chan_type'(req_table_channel)) +
                       ADDR_W'(req_table_index);
   assign rd_comp  = comp_ff[slot_ff];
   assign rd_zero  = ({1'b0, rd_comp} >= (LEVEL_W+1)'(LEVELS_PER_CHANNEL));
   assign rd_addr  = chan_base(slot_chan(slot_ff)) + ADDR_W'(rd_comp);
   assign last_plane = ((DEPTH_W'(plane_ff) + DEPTH_W'(1)) == depth_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_PIXEL) begin
                  state_in = ST_FETCH;
               end else if (write_ok) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP:  state_in = ST_SPREAD;
         ST_SPREAD: begin
            if (spread_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE:  state_in = ST_IDLE;
         ST_FETCH: begin
            if (slot_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_stall && last_plane) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_EMIT);
      spread_ctl.load  = (state_ff == ST_IDLE) && req_valid &&
                         (req_kind == KIND_TABLE) && write_ok;
      spread_ctl.setup = (state_ff == ST_SETUP);
      spread_ctl.step  = (state_ff == ST_SPREAD);
      ram_wr_en        = (state_ff == ST_STORE);
      ram_rd_en        = (state_ff == ST_FETCH);
      shift_en         = (state_ff == ST_EMIT) && !rsp_stall;
   end

   always_comb begin
      depth_in = depth_ff;
      if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            depth_in = DEPTH_W'(1);
         end else if (csr_wr_data > DEPTH_MAX) begin
            depth_in = DEPTH_MAX;
         end else begin
            depth_in = csr_wr_data;
         end
      end
      slot_in = (state_ff == ST_FETCH) ? slot_ff + SLOT_W'(1) : '0;
      plane_in = plane_ff;
      if (shift_en) begin
         plane_in = last_plane ? '0 : plane_ff + PLANE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         depth_ff    <= DEPTH_RESET;
         slot_ff     <= '0;
         plane_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         slot_ff     <= slot_in;
         plane_ff    <= plane_in;
         rd_valid_ff <= ram_rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= slot_ff;
      rd_zero_ff <= rd_zero;
      if (accept) begin
         port_ff    <= req_port;
         wr_addr_ff <= table_addr;
         comp_ff[0] <= req_upper_red;
         comp_ff[1] <= req_upper_green;
         comp_ff[2] <= req_upper_blue;
         comp_ff[3] <= req_lower_red;
         comp_ff[4] <= req_lower_green;
         comp_ff[5] <= req_lower_blue;
      end
   end

   assign cap.en   = rd_valid_ff;
   assign cap.zero = rd_zero_ff;
   assign cap.slot = rd_slot_ff;

   ledbpe_spread_unit #(
      .WIDTH (MAX_PLANES)
   ) u_spread (
      .clock     (clock),
      .ctl       (spread_ctl),
      .level     (req_table_level),
      .depth     (depth_ff),
      .pattern   (spread_pattern),
      .last_step (spread_last)
   );

   ledbpe_pattern_ram #(
      .ENTRIES (ENTRIES),
      .WIDTH   (MAX_PLANES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (spread_pattern),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ledbpe_plane_shifter #(
      .WIDTH (MAX_PLANES)
   ) u_shifter (
      .clock      (clock),
      .cap        (cap),
      .rd_data    (rd_data),
      .shift_en   (shift_en),
      .plane_bits (plane_bits)
   );

   assign rsp_out_port  = port_ff;
   assign rsp_plane     = plane_ff;
   assign rsp_red_one   = plane_bits[0];
   assign rsp_green_one = plane_bits[1];
   assign rsp_blue_one  = plane_bits[2];
   assign rsp_red_two   = plane_bits[3];
   assign rsp_green_two = plane_bits[4];
   assign rsp_blue_two  = plane_bits[5];
   assign rsp_last      = last_plane;

endmodule

>>> sv/ledbpe_checker.sv
// Port-level checks of the encoder's result sequence, bound to the top level.
// Depends on ledbpe_pkg and on the port names of led_panel_bit_plane_encoder.
module ledbpe_checker
   import ledbpe_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [PORT_W-1:0]  rsp_out_port,
   input logic [PLANE_W-1:0] rsp_plane,
   input logic               rsp_last
);

   logic rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_valid)
      else $error("input transaction accepted while results were pending");

   a_first_plane_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_plane == '0))
      else $error("result sequence did not start at plane zero");

   a_plane_advances: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last) |=>
         (rsp_valid && rsp_plane == $past(rsp_plane) + PLANE_W'(1) &&
          rsp_out_port == $past(rsp_out_port)))
      else $error("plane sequence broken within a pixel pair");

   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last) |=> !rsp_valid)
      else $error("result shown after the final plane");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_plane)))
      else $error("stalled result transaction changed");

endmodule

bind led_panel_bit_plane_encoder ledbpe_checker u_checker (.*);

>>> verif/led_panel_bit_plane_encoder_checker.sv
// Checker of the LED panel bit-plane encoder: watches the req_, rsp_ and csr_
// ports, keeps its own pattern store and depth, and compares every result
// transaction with the planes it predicts. Depends on ledbpe_pkg.
module led_panel_bit_plane_encoder_checker
   import ledbpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [DEPTH_W-1:0] csr_wr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_kind,
   input  logic [CHAN_W-1:0]  req_table_channel,
   input  logic [LEVEL_W-1:0] req_table_index,
   input  logic [LEVEL_W-1:0] req_table_level,
   input  logic [PORT_W-1:0]  req_port,
   input  logic [LEVEL_W-1:0] req_upper_red,
   input  logic [LEVEL_W-1:0] req_upper_green,
   input  logic [LEVEL_W-1:0] req_upper_blue,
   input  logic [LEVEL_W-1:0] req_lower_red,
   input  logic [LEVEL_W-1:0] req_lower_green,
   input  logic [LEVEL_W-1:0] req_lower_blue,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [PORT_W-1:0]  rsp_out_port,
   input  logic [PLANE_W-1:0] rsp_plane,
   input  logic               rsp_red_one,
   input  logic               rsp_red_two,
   input  logic               rsp_green_one,
   input  logic               rsp_green_two,
   input  logic               rsp_blue_one,
   input  logic               rsp_blue_two,
   input  logic               rsp_last,
   output int                 error_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS     = 256;
   localparam int MAX_PLANES = 64;
   localparam int DEPTH_AT_RESET = 32;

   typedef struct packed {
      logic [PORT_W-1:0]  out_port;
      logic [PLANE_W-1:0] plane;
      logic               red_one;
      logic               red_two;
      logic               green_one;
      logic               green_two;
      logic               blue_one;
      logic               blue_two;
      logic               last;
   } bit_plane_type;

   bit_plane_type      expected_planes[$];
   bit_plane_type      want;
   logic [63:0]        pattern_store [0:3*LEVELS-1];
   logic [DEPTH_W-1:0] depth_setting;
   logic [63:0]        up_r, up_g, up_b, lo_r, lo_g, lo_b;
   int                 planes;

   function automatic int plane_count(input logic [DEPTH_W-1:0] setting);
      int d;
      d = int'(setting);
      if (d < 1) d = 1;
      if (d > MAX_PLANES) d = MAX_PLANES;
      return d;
   endfunction

   function automatic logic [63:0] spread_ones(input int unsigned level,
                                               input int unsigned depth);
      int unsigned count;
      logic [63:0] pattern;
      pattern = '0;
      count = level * depth / 255;
      if (level == 0) return pattern;
      if (count == 0) count = 1;
      for (int unsigned i = 0; i < count; i++) pattern[(i * depth / count) % 64] = 1'b1;
      return pattern;
   endfunction

   function automatic int store_slot(input int chan, input logic [LEVEL_W-1:0] value);
      return chan * LEVELS + int'(value);
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_value,
                              input logic [7:0] act_value);
      if (act_value !== exp_value) begin
         $error("%s: expected %0d, actual %0d", name, exp_value, act_value);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         depth_setting = DEPTH_W'(DEPTH_AT_RESET);
         expected_planes.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_planes.size() == 0) begin
               $error("result transaction with nothing expected: port %0d plane %0d",
                      rsp_out_port, rsp_plane);
               error_count++;
            end else begin
               want = expected_planes.pop_front();
               check_field("out_port", want.out_port, rsp_out_port);
               check_field("plane", want.plane, rsp_plane);
               check_field("red_one", want.red_one, rsp_red_one);
               check_field("red_two", want.red_two, rsp_red_two);
               check_field("green_one", want.green_one, rsp_green_one);
               check_field("green_two", want.green_two, rsp_green_two);
               check_field("blue_one", want.blue_one, rsp_blue_one);
               check_field("blue_two", want.blue_two, rsp_blue_two);
               check_field("last", want.last, rsp_last);
            end
         end
         if (csr_wr_en) depth_setting = csr_wr_data;
         if (req_valid && !req_stall) begin
            planes = plane_count(depth_setting);
            if (req_kind == KIND_TABLE) begin
               if (req_table_channel <= CH_BLUE)
                  pattern_store[store_slot(int'(req_table_channel), req_table_index)] =
                     spread_ones(req_table_level, planes);
            end else begin
               up_r = pattern_store[store_slot(CH_RED, req_upper_red)];
               up_g = pattern_store[store_slot(CH_GREEN, req_upper_green)];
               up_b = pattern_store[store_slot(CH_BLUE, req_upper_blue)];
               lo_r = pattern_store[store_slot(CH_RED, req_lower_red)];
               lo_g = pattern_store[store_slot(CH_GREEN, req_lower_green)];
               lo_b = pattern_store[store_slot(CH_BLUE, req_lower_blue)];
               for (int p = 0; p < planes; p++) begin
                  want.out_port  = req_port;
                  want.plane     = PLANE_W'(p);
                  want.red_one   = up_r[p];
                  want.red_two   = lo_r[p];
                  want.green_one = up_g[p];
                  want.green_two = lo_g[p];
                  want.blue_one  = up_b[p];
                  want.blue_two  = lo_b[p];
                  want.last      = (p == planes - 1);
                  expected_planes.push_back(want);
               end
            end
         end
      end
      pending_count <= expected_planes.size();
   end

endmodule

>>> verif/led_panel_bit_plane_encoder_test.sv
// Top of the LED panel bit-plane encoder testbench: clock, reset, stimulus
// and verdict. Depends on ledbpe_pkg, the block and its checker module.
module led_panel_bit_plane_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ledbpe_pkg::*;

   localparam int RANDOM_ITEMS  = 184;
   localparam int SETTLE_CYCLES = 80;
   localparam int FILL_SPAN     = 16;
   localparam logic [CHAN_W-1:0] CH_INVALID = 2'd3;

   typedef struct packed {
      logic               kind;
      logic [CHAN_W-1:0]  table_channel;
      logic [LEVEL_W-1:0] table_index;
      logic [LEVEL_W-1:0] table_level;
      logic [PORT_W-1:0]  port;
      logic [LEVEL_W-1:0] upper_red;
      logic [LEVEL_W-1:0] upper_green;
      logic [LEVEL_W-1:0] upper_blue;
      logic [LEVEL_W-1:0] lower_red;
      logic [LEVEL_W-1:0] lower_green;
      logic [LEVEL_W-1:0] lower_blue;
   } pixel_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [DEPTH_W-1:0] csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = 1'b0;
   logic [CHAN_W-1:0]  req_table_channel = '0;
   logic [LEVEL_W-1:0] req_table_index = '0;
   logic [LEVEL_W-1:0] req_table_level = '0;
   logic [PORT_W-1:0]  req_port = '0;
   logic [LEVEL_W-1:0] req_upper_red = '0;
   logic [LEVEL_W-1:0] req_upper_green = '0;
   logic [LEVEL_W-1:0] req_upper_blue = '0;
   logic [LEVEL_W-1:0] req_lower_red = '0;
   logic [LEVEL_W-1:0] req_lower_green = '0;
   logic [LEVEL_W-1:0] req_lower_blue = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PORT_W-1:0]  rsp_out_port;
   logic [PLANE_W-1:0] rsp_plane;
   logic               rsp_red_one, rsp_red_two;
   logic               rsp_green_one, rsp_green_two;
   logic               rsp_blue_one, rsp_blue_two;
   logic               rsp_last;
   int                 error_count;
   int                 pending_count;

   int                 burst_left = 0;
   int                 stall_mode = 0;
   int                 stall_left = 0;
   int                 items_done;
   int                 depth_plan[8];
   pixel_request_type  item;

   always #5 clock = ~clock;

   led_panel_bit_plane_encoder DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_table_channel(req_table_channel), .req_table_index(req_table_index),
      .req_table_level(req_table_level), .req_port(req_port),
      .req_upper_red(req_upper_red), .req_upper_green(req_upper_green),
      .req_upper_blue(req_upper_blue), .req_lower_red(req_lower_red),
      .req_lower_green(req_lower_green), .req_lower_blue(req_lower_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_port(rsp_out_port),
      .rsp_plane(rsp_plane), .rsp_red_one(rsp_red_one), .rsp_red_two(rsp_red_two),
      .rsp_green_one(rsp_green_one), .rsp_green_two(rsp_green_two),
      .rsp_blue_one(rsp_blue_one), .rsp_blue_two(rsp_blue_two), .rsp_last(rsp_last)
   );

   led_panel_bit_plane_encoder_checker plane_checker (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_table_channel(req_table_channel), .req_table_index(req_table_index),
      .req_table_level(req_table_level), .req_port(req_port),
      .req_upper_red(req_upper_red), .req_upper_green(req_upper_green),
      .req_upper_blue(req_upper_blue), .req_lower_red(req_lower_red),
      .req_lower_green(req_lower_green), .req_lower_blue(req_lower_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_port(rsp_out_port),
      .rsp_plane(rsp_plane), .rsp_red_one(rsp_red_one), .rsp_red_two(rsp_red_two),
      .rsp_green_one(rsp_green_one), .rsp_green_two(rsp_green_two),
      .rsp_blue_one(rsp_blue_one), .rsp_blue_two(rsp_blue_two), .rsp_last(rsp_last),
      .error_count(error_count), .pending_count(pending_count)
   );

   // The receiver switches between stall patterns at random intervals.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 64);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 25);
         2: rsp_stall <= ($urandom_range(0, 99) < 70);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   function automatic logic [LEVEL_W-1:0] pick_level();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return 8'd0;
      if (roll < 30) return 8'd255;
      if (roll < 35) return 8'd1;
      if (roll < 40) return 8'd254;
      return LEVEL_W'($urandom_range(0, 255));
   endfunction

   // Pixel values are drawn from the low and high ends of the table only,
   // which are the entries written before any pixel pair is sent.
   function automatic int fill_value(input int k);
      return (k < FILL_SPAN) ? k : 256 - 2 * FILL_SPAN + k;
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_index();
      return LEVEL_W'(fill_value($urandom_range(0, 2 * FILL_SPAN - 1)));
   endfunction

   function automatic pixel_request_type random_item();
      pixel_request_type r;
      r.kind          = ($urandom_range(0, 99) < 40) ? KIND_TABLE : KIND_PIXEL;
      r.table_channel = ($urandom_range(0, 9) == 0) ? CH_INVALID
                                                    : CHAN_W'($urandom_range(0, 2));
      r.table_index   = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(0, 255))
                                                    : pick_index();
      r.table_level   = pick_level();
      r.port          = PORT_W'($urandom_range(0, 3));
      r.upper_red     = pick_index();
      r.upper_green   = pick_index();
      r.upper_blue    = pick_index();
      r.lower_red     = pick_index();
      r.lower_green   = pick_index();
      r.lower_blue    = pick_index();
      return r;
   endfunction

   function automatic pixel_request_type table_item(input logic [CHAN_W-1:0] chan,
                                                    input int index, input int level);
      pixel_request_type r;
      r               = random_item();
      r.kind          = KIND_TABLE;
      r.table_channel = chan;
      r.table_index   = LEVEL_W'(index);
      r.table_level   = LEVEL_W'(level);
      return r;
   endfunction

   function automatic pixel_request_type pixel_item(input int port, input int ur,
                                                    input int ug, input int ub,
                                                    input int lr, input int lg,
                                                    input int lb);
      pixel_request_type r;
      r             = random_item();
      r.kind        = KIND_PIXEL;
      r.port        = PORT_W'(port);
      r.upper_red   = LEVEL_W'(ur);
      r.upper_green = LEVEL_W'(ug);
      r.upper_blue  = LEVEL_W'(ub);
      r.lower_red   = LEVEL_W'(lr);
      r.lower_green = LEVEL_W'(lg);
      r.lower_blue  = LEVEL_W'(lb);
      return r;
   endfunction

   // Items go out in bursts; between bursts the sender may drop req_valid for a random gap.
   task automatic send(input pixel_request_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_kind          <= r.kind;
      req_table_channel <= r.table_channel;
      req_table_index   <= r.table_index;
      req_table_level   <= r.table_level;
      req_port          <= r.port;
      req_upper_red     <= r.upper_red;
      req_upper_green   <= r.upper_green;
      req_upper_blue    <= r.upper_blue;
      req_lower_red     <= r.lower_red;
      req_lower_green   <= r.lower_green;
      req_lower_blue    <= r.lower_blue;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_depth(input int depth);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= DEPTH_W'(depth);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The entries that pixel pairs read are written first, at the depth
      // left by reset.
      for (int ch = 0; ch < 3; ch++)
         for (int k = 0; k < 2 * FILL_SPAN; k++)
            send(table_item(CHAN_W'(ch), fill_value(k), pick_level()));

      send(table_item(CH_RED, 0, 0));
      send(table_item(CH_GREEN, 255, 255));
      send(table_item(CH_BLUE, 1, 1));
      send(table_item(CH_RED, 255, 254));
      send(table_item(CH_INVALID, 0, 255));
      send(pixel_item(0, 0, 255, 1, 255, 255, 1));
      send(pixel_item(3, 255, 0, 255, 0, 0, 0));
      set_depth(64);
      send(table_item(CH_RED, 1, 1));
      send(table_item(CH_GREEN, 0, 254));
      send(table_item(CH_BLUE, 255, 255));
      send(pixel_item(1, 1, 0, 255, 0, 255, 1));
      send(pixel_item(2, 255, 255, 255, 1, 0, 0));
      set_depth(1);
      send(table_item(CH_RED, 2, 1));
      send(table_item(CH_GREEN, 2, 128));
      send(pixel_item(3, 2, 2, 255, 0, 2, 1));
      set_depth(0);
      send(table_item(CH_BLUE, 2, 200));
      send(pixel_item(0, 2, 255, 2, 255, 0, 2));
      set_depth(127);
      send(table_item(CH_RED, 3, 255));
      send(table_item(CH_BLUE, 3, 3));
      send(pixel_item(2, 3, 0, 3, 1, 255, 255));

      depth_plan = '{2, 64, 1, 127, 0, 63, 32, 32};
      depth_plan[6] = $urandom_range(1, 64);
      depth_plan[7] = $urandom_range(0, 127);
      items_done = 0;
      for (int phase = 0; phase < 8; phase++) begin
         set_depth(depth_plan[phase]);
         while (items_done < (phase + 1) * RANDOM_ITEMS / 8) begin
            item = random_item();
            send(item);
            if (!(item.kind == KIND_TABLE && item.table_channel == CH_INVALID))
               items_done++;
            if ($urandom_range(0, 39) == 0) wait_drained();
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
sv/ledbpe_pkg.sv
sv/ledbpe_pattern_ram.sv
sv/ledbpe_spread_unit.sv
sv/ledbpe_plane_shifter.sv
sv/led_panel_bit_plane_encoder.sv
sv/ledbpe_checker.sv
verif/led_panel_bit_plane_encoder_checker.sv
verif/led_panel_bit_plane_encoder_test.sv
